[hw/rtl/ghtab_pkg.sv]
// shared types, constants and helpers for the generational handle table
package ghtab_pkg;

   localparam int PROCESS_SLOTS = 64;
   localparam int LIBRARY_SLOTS = 64;

   localparam int ProcIdxW = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
   localparam int LibIdxW  = (LIBRARY_SLOTS > 1) ? $clog2(LIBRARY_SLOTS) : 1;
   localparam int LibCntW  = $clog2(LIBRARY_SLOTS + 1);

   localparam int ModeW      = 2;
   localparam int OwnerW     = 64;
   localparam int HandleW    = 48;
   localparam int SlotFieldW = 16;
   localparam int GenW       = 32;
   localparam int BaseW      = 29;
   localparam int CountW     = 9;

   localparam logic [GenW-1:0]  GenMax         = 32'hffff_ffff;
   localparam logic [BaseW-1:0] LibBase        = 29'h1000_0000;
   localparam int               LibStrideShift = 20;

   localparam logic [ModeW-1:0] ModeCreate  = 2'd0;
   localparam logic [ModeW-1:0] ModeDestroy = 2'd1;
   localparam logic [ModeW-1:0] ModeLoad    = 2'd2;

   localparam logic StatusOk   = 1'b0;
   localparam logic StatusFail = 1'b1;

   typedef struct packed {
      logic [ModeW-1:0]   mode;
      logic [OwnerW-1:0]  owner_task;
      logic [HandleW-1:0] handle;
   } req_type;

   typedef struct packed {
      logic               status;
      logic [HandleW-1:0] result_id;
      logic [BaseW-1:0]   lib_base_addr;
      logic [CountW-1:0]  library_count;
   } rsp_type;

   // one word of the slot memory
   typedef struct packed {
      logic [LibCntW-1:0] lib_total;
      logic [GenW-1:0]    gen;
   } entry_type;

   localparam int EntryW = $bits(entry_type);

   // commit from the execute step into the slot flags
   typedef struct packed {
      logic                create;
      logic                destroy;
      logic                load;
      logic                saturate;
      logic [ProcIdxW-1:0] proc_idx;
      logic [LibIdxW-1:0]  lib_idx;
   } slot_upd_type;

   // free-slot picks and flags of the looked-up slot
   typedef struct packed {
      logic                proc_found;
      logic [ProcIdxW-1:0] proc_idx;
      logic                lib_found;
      logic [LibIdxW-1:0]  lib_idx;
      logic                in_use;
      logic                gen_valid;
   } slot_stat_type;

   typedef struct packed {
      logic                found;
      logic [ProcIdxW-1:0] idx;
   } proc_pick_type;

   typedef struct packed {
      logic               found;
      logic [LibIdxW-1:0] idx;
   } lib_pick_type;

   // lowest clear bit of the taken mask
   function automatic proc_pick_type pick_proc(input logic [PROCESS_SLOTS-1:0] taken);
      proc_pick_type p;
      p = '0;
      for (int i = PROCESS_SLOTS - 1; i >= 0; i--) begin
         if (!taken[i]) begin
            p.found = 1'b1;
            p.idx   = ProcIdxW'(i);
         end
      end
      return p;
   endfunction

   function automatic lib_pick_type pick_lib(input logic [LIBRARY_SLOTS-1:0] taken);
      lib_pick_type p;
      p = '0;
      for (int i = LIBRARY_SLOTS - 1; i >= 0; i--) begin
         if (!taken[i]) begin
            p.found = 1'b1;
            p.idx   = LibIdxW'(i);
         end
      end
      return p;
   endfunction

endpackage

[hw/rtl/ghtab_ram.sv]
// generic single-port-write, registered-read memory
module ghtab_ram #(
   parameter int Width = 8,
   parameter int Depth = 16,
   parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/ghtab_slot_sel.sv]
// per-slot flags and lowest-free-slot selection for processes and libraries
module ghtab_slot_sel (
   input  logic                          clock,
   input  logic                          reset,
   input  ghtab_pkg::slot_upd_type       upd,
   input  logic [ghtab_pkg::ProcIdxW-1:0] look_idx,
   output ghtab_pkg::slot_stat_type      stat
);

   logic [ghtab_pkg::PROCESS_SLOTS-1:0] proc_in_use_ff, proc_in_use_in;
   logic [ghtab_pkg::PROCESS_SLOTS-1:0] proc_sat_ff, proc_sat_in;
   logic [ghtab_pkg::PROCESS_SLOTS-1:0] gen_valid_ff, gen_valid_in;
   logic [ghtab_pkg::LIBRARY_SLOTS-1:0] lib_in_use_ff, lib_in_use_in;

   ghtab_pkg::proc_pick_type proc_pick;
   ghtab_pkg::lib_pick_type  lib_pick;

   always_comb begin
      proc_in_use_in = proc_in_use_ff;
      proc_sat_in    = proc_sat_ff;
      gen_valid_in   = gen_valid_ff;
      lib_in_use_in  = lib_in_use_ff;
      if (upd.create) begin
         proc_in_use_in[upd.proc_idx] = 1'b1;
         gen_valid_in[upd.proc_idx]   = 1'b1;
         proc_sat_in[upd.proc_idx]    = upd.saturate;
      end
      if (upd.destroy) begin
         proc_in_use_in[upd.proc_idx] = 1'b0;
      end
      if (upd.load) begin
         lib_in_use_in[upd.lib_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         proc_in_use_ff <= '0;
         proc_sat_ff    <= '0;
         gen_valid_ff   <= '0;
         lib_in_use_ff  <= '0;
      end else begin
         proc_in_use_ff <= proc_in_use_in;
         proc_sat_ff    <= proc_sat_in;
         gen_valid_ff   <= gen_valid_in;
         lib_in_use_ff  <= lib_in_use_in;
      end
   end

   // saturated slots are never handed out again
   assign proc_pick = ghtab_pkg::pick_proc(proc_in_use_ff | proc_sat_ff);
   assign lib_pick  = ghtab_pkg::pick_lib(lib_in_use_ff);

   always_comb begin
      stat.proc_found = proc_pick.found;
      stat.proc_idx   = proc_pick.idx;
      stat.lib_found  = lib_pick.found;
      stat.lib_idx    = lib_pick.idx;
      stat.in_use     = proc_in_use_ff[look_idx];
      stat.gen_valid  = gen_valid_ff[look_idx];
   end

endmodule

[hw/rtl/generational_handle_table.sv]
// top level of the generational handle table
//
// Each request passes from idle to execute: busy is high in the cycle after
// start is taken while the slot memory word (generation and library count)
// comes back from its registered read, and the update is written back at the
// end of that cycle. No new start is taken while busy is high. The result
// appears on rsp_data with rsp_strobe high for exactly one cycle, the cycle
// right after the busy cycle; the receiver cannot stall it, so it must capture
// the transfer in that cycle. Create returns the handle generation<<16 | slot+1
// for the lowest free, non-saturated process slot; destroy frees a live
// handle; load claims the lowest free library slot for a live handle and
// returns its id, base address and the process's new library count. Any
// failure returns status 1 with all other fields zero and changes nothing.
// No clearing pass is needed after reset: slot flags reset at once.
module generational_handle_table (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  ghtab_pkg::req_type req_data,
   output logic               rsp_strobe,
   output ghtab_pkg::rsp_type rsp_data
);

   // sequencer codes
   localparam logic StIdle = 1'b0;
   localparam logic StExec = 1'b1;

   logic state_ff, state_in;

   ghtab_pkg::req_type                req_ff, req_in;
   logic [ghtab_pkg::ProcIdxW-1:0]    addr_ff, addr_in;
   logic                              rsp_strobe_ff, rsp_strobe_in;
   ghtab_pkg::rsp_type                rsp_ff, rsp_in;

   logic                              accept;
   logic [ghtab_pkg::SlotFieldW-1:0]  req_slot_m1;
   logic [ghtab_pkg::ProcIdxW-1:0]    rd_addr;

   ghtab_pkg::slot_upd_type           upd;
   ghtab_pkg::slot_stat_type          stat;

   logic                              wr_en;
   ghtab_pkg::entry_type              wr_entry;
   logic [ghtab_pkg::EntryW-1:0]      rd_word;
   ghtab_pkg::entry_type              rd_entry;

   // execute-step values
   logic [ghtab_pkg::GenW-1:0]        gen_cur;
   logic [ghtab_pkg::GenW-1:0]        gen_next;
   logic [ghtab_pkg::SlotFieldW-1:0]  h_slot;
   logic [ghtab_pkg::GenW-1:0]        h_gen;
   logic                              handle_ok;
   logic [ghtab_pkg::LibCntW-1:0]     total_next;

   assign busy   = (state_ff == StExec);
   assign accept = start && !busy;

   // memory address: free slot for create, handle slot otherwise
   assign req_slot_m1 = req_data.handle[ghtab_pkg::SlotFieldW-1:0] -
                        ghtab_pkg::SlotFieldW'(1);
   assign rd_addr = (req_data.mode == ghtab_pkg::ModeCreate) ?
                    stat.proc_idx : req_slot_m1[ghtab_pkg::ProcIdxW-1:0];

   ghtab_ram #(
      .Width (ghtab_pkg::EntryW),
      .Depth (ghtab_pkg::PROCESS_SLOTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (wr_entry),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_entry = rd_word;

   ghtab_slot_sel u_slot_sel (
      .clock    (clock),
      .reset    (reset),
      .upd      (upd),
      .look_idx (addr_ff),
      .stat     (stat)
   );

   // never-written generations read as zero
   assign gen_cur    = stat.gen_valid ? rd_entry.gen : '0;
   assign gen_next   = gen_cur + ghtab_pkg::GenW'(1);
   assign total_next = rd_entry.lib_total + ghtab_pkg::LibCntW'(1);

   // handle split and liveness check
   assign h_slot = req_ff.handle[ghtab_pkg::SlotFieldW-1:0];
   assign h_gen  = req_ff.handle[ghtab_pkg::HandleW-1:ghtab_pkg::SlotFieldW];
   assign handle_ok = (h_slot != '0) &&
                      (h_slot <= ghtab_pkg::SlotFieldW'(ghtab_pkg::PROCESS_SLOTS)) &&
                      (h_gen != '0) && stat.in_use && (gen_cur == h_gen);

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      addr_in       = addr_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      upd           = '0;
      upd.proc_idx  = addr_ff;
      upd.lib_idx   = stat.lib_idx;
      wr_en         = 1'b0;
      wr_entry      = rd_entry;

      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               req_in   = req_data;
               addr_in  = rd_addr;
               state_in = StExec;
            end
         end
         StExec: begin
            state_in      = StIdle;
            rsp_strobe_in = 1'b1;
            rsp_in        = '0;
            rsp_in.status = ghtab_pkg::StatusFail;
            unique case (req_ff.mode)
               ghtab_pkg::ModeCreate: begin
                  if ((req_ff.owner_task != '0) && stat.proc_found) begin
                     upd.create         = 1'b1;
                     upd.saturate       = (gen_next == ghtab_pkg::GenMax);
                     wr_en              = 1'b1;
                     wr_entry.gen       = gen_next;
                     wr_entry.lib_total = '0;
                     rsp_in.status      = ghtab_pkg::StatusOk;
                     rsp_in.result_id   = {gen_next,
                        ghtab_pkg::SlotFieldW'(addr_ff) + ghtab_pkg::SlotFieldW'(1)};
                  end
               end
               ghtab_pkg::ModeDestroy: begin
                  if (handle_ok) begin
                     upd.destroy   = 1'b1;
                     rsp_in.status = ghtab_pkg::StatusOk;
                  end
               end
               ghtab_pkg::ModeLoad: begin
                  if (handle_ok && stat.lib_found) begin
                     upd.load           = 1'b1;
                     wr_en              = 1'b1;
                     wr_entry.lib_total = total_next;
                     rsp_in.status      = ghtab_pkg::StatusOk;
                     rsp_in.result_id   = ghtab_pkg::HandleW'(stat.lib_idx) +
                                          ghtab_pkg::HandleW'(1);
                     rsp_in.lib_base_addr = ghtab_pkg::LibBase +
                        (ghtab_pkg::BaseW'(stat.lib_idx) << ghtab_pkg::LibStrideShift);
                     rsp_in.library_count = ghtab_pkg::CountW'(total_next);
                  end
               end
               default: begin
                  // unused mode: failure, no change
               end
            endcase
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= StIdle;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      addr_ff <= addr_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

[hw/rtl/ghtab_checker.sv]
// port-level checks for the generational handle table, bound to the top level
module ghtab_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input ghtab_pkg::req_type req_data,
   input logic               rsp_strobe,
   input ghtab_pkg::rsp_type rsp_data
);

   // every taken request holds busy for the memory read cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after a request transfer");

   // each taken request is followed by a result strobe
   a_result_timing: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("result transfer missing after a request");

   // results never come back to back
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");

   // no result without a request: the strobe comes only as busy falls
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy && $past(busy))
      else $error("result transfer without a request");

   // failures carry all-zero payload
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == ghtab_pkg::StatusFail) |->
         (rsp_data.result_id == '0) && (rsp_data.lib_base_addr == '0) &&
         (rsp_data.library_count == '0))
      else $error("failed result carries nonzero fields");

endmodule

bind generational_handle_table ghtab_checker u_ghtab_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
